FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/zbp_pkg.sv
// Shared types, constants and helper functions for the point projector.
// No dependencies.
`default_nettype none
package zbp_pkg;

    localparam int SCREEN_WIDTH  = 100;
    localparam int SCREEN_HEIGHT = 43;
    localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int IDX_W         = $clog2(PIXELS);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);

    // Fixed-point widths
    localparam int Z_W   = 32;   // projected coordinates, Q16 fraction
    localparam int NUM_W = 42;   // projection numerators
    localparam int SUM_W = 66;   // exact rotation sums

    localparam logic signed [Z_W-1:0] CAM_DIST_Q16 = Z_W'(120 * 65536);
    localparam logic signed [Z_W-1:0] NEAR_Q16     = Z_W'(65);
    localparam int FOCAL = 40;

    localparam logic [7:0]  BLANK_CHAR = 8'd32;
    localparam logic [15:0] MAX_DEPTH  = 16'hFFFF;
    localparam logic [15:0] SAT_DEPTH  = 16'hFFFE;

    // Commands
    localparam logic [1:0] CMD_PLOT  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_SIN_A = 3'd0;
    localparam logic [2:0] REG_COS_A = 3'd1;
    localparam logic [2:0] REG_SIN_B = 3'd2;
    localparam logic [2:0] REG_COS_B = 3'd3;
    localparam logic [2:0] REG_SIN_C = 3'd4;
    localparam logic [2:0] REG_COS_C = 3'd5;
    localparam logic [2:0] REG_COL_OFF = 3'd6;

    typedef struct packed {
        logic signed [15:0] sin_a;
        logic signed [15:0] cos_a;
        logic signed [15:0] sin_b;
        logic signed [15:0] cos_b;
        logic signed [15:0] sin_c;
        logic signed [15:0] cos_c;
    } t_rot_cfg;

    // Shade ramp ".,-~:;=!*#$@"
    function automatic logic [7:0] shade_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h2E;
            4'd1:    c = 8'h2C;
            4'd2:    c = 8'h2D;
            4'd3:    c = 8'h7E;
            4'd4:    c = 8'h3A;
            4'd5:    c = 8'h3B;
            4'd6:    c = 8'h3D;
            4'd7:    c = 8'h21;
            4'd8:    c = 8'h2A;
            4'd9:    c = 8'h23;
            4'd10:   c = 8'h24;
            default: c = 8'h40;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/zbp_rotate.sv
// Four-stage rotation pipeline: Q6.8 point to Q16 camera coordinates.
// Depends on zbp_pkg.
`default_nettype none
module zbp_rotate
    import zbp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  t_rot_cfg             i_cfg,
    input  wire signed [13:0]    i_ci,
    input  wire signed [13:0]    i_cj,
    input  wire signed [13:0]    i_ck,
    output logic                 o_valid,
    output logic signed [Z_W-1:0] o_x16,
    output logic signed [Z_W-1:0] o_y16,
    output logic signed [Z_W-1:0] o_z16
);

    logic [3:0] r_vld;

    // stage 1
    logic signed [29:0] m_jsa, m_kca, m_jca, m_ksa;
    logic signed [30:0] r_p, r_q1;
    logic signed [13:0] r_i1;
    // stage 2
    logic signed [46:0] r_a, r_pcb;
    logic signed [29:0] r_b, r_isb;
    logic signed [30:0] r_q2;
    // stage 3
    logic signed [62:0] r_acc, r_asc;
    logic signed [46:0] r_qsc, r_qcc;
    logic signed [45:0] r_bcc, r_bsc;
    logic signed [46:0] r_pcb3;
    logic signed [29:0] r_isb3;
    // stage 4
    logic signed [SUM_W-1:0] m_xr, m_yr, m_zr;

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end
    assign o_valid = r_vld[3];

    always_comb begin
        m_jsa = i_cj * i_cfg.sin_a;
        m_kca = i_ck * i_cfg.cos_a;
        m_jca = i_cj * i_cfg.cos_a;
        m_ksa = i_ck * i_cfg.sin_a;
    end

    // sums over the stage 3 products; floor comes from the arithmetic shift
    always_comb begin
        m_xr = SUM_W'(r_acc) + ((SUM_W'(r_qsc) + SUM_W'(r_bcc)) <<< 14);
        m_yr = ((SUM_W'(r_qcc) - SUM_W'(r_bsc)) <<< 14) - SUM_W'(r_asc);
        m_zr = (SUM_W'(r_isb3) <<< 28) - (SUM_W'(r_pcb3) <<< 14);
    end

    always_ff @(posedge i_clk) begin
        r_p    <= 31'(m_jsa) - 31'(m_kca);
        r_q1   <= 31'(m_jca) + 31'(m_ksa);
        r_i1   <= i_ci;

        r_a    <= r_p * i_cfg.sin_b;
        r_pcb  <= r_p * i_cfg.cos_b;
        r_b    <= r_i1 * i_cfg.cos_b;
        r_isb  <= r_i1 * i_cfg.sin_b;
        r_q2   <= r_q1;

        r_acc  <= r_a * i_cfg.cos_c;
        r_asc  <= r_a * i_cfg.sin_c;
        r_qsc  <= r_q2 * i_cfg.sin_c;
        r_qcc  <= r_q2 * i_cfg.cos_c;
        r_bcc  <= r_b * i_cfg.cos_c;
        r_bsc  <= r_b * i_cfg.sin_c;
        r_pcb3 <= r_pcb;
        r_isb3 <= r_isb;

        o_x16  <= Z_W'(m_xr >>> 34);
        o_y16  <= Z_W'(m_yr >>> 34);
        o_z16  <= Z_W'(m_zr >>> 34) + CAM_DIST_Q16;
    end

endmodule
`default_nettype wire

FILE: rtl/core/zbp_divider.sv
// Two-lane restoring divider, one quotient bit per cycle, shared denominator.
// Quotient magnitude truncated toward zero plus sign. Depends on zbp_pkg.
`default_nettype none
module zbp_divider
    import zbp_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire signed [NUM_W-1:0] i_num [2],
    input  wire [Z_W-1:0]         i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot [2],
    output logic                  o_neg [2]
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [Z_W-1:0]   r_den;
    logic [Z_W:0]     r_rem [2];
    logic [Z_W:0]     m_sh [2];
    logic             m_ge [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            m_sh[l] = {r_rem[l][Z_W-1:0], o_quot[l][NUM_W-1]};
            m_ge[l] = (m_sh[l] >= {1'b0, r_den});
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int l = 0; l < 2; l++) begin
                o_neg[l]  <= i_num[l][NUM_W-1];
                o_quot[l] <= i_num[l][NUM_W-1] ? NUM_W'(-i_num[l]) : i_num[l];
                r_rem[l]  <= '0;
            end
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l]  <= m_ge[l] ? (m_sh[l] - {1'b0, r_den}) : m_sh[l];
                o_quot[l] <= {o_quot[l][NUM_W-2:0], m_ge[l]};
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/zbp_store.sv
// Pixel store: character and depth memories, one port, registered read.
// Sweeps every entry to blank / maximum depth after reset. Depends on zbp_pkg.
`default_nettype none
module zbp_store
    import zbp_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_rd,
    input  wire             i_we,
    input  wire [IDX_W-1:0] i_addr,
    input  wire [7:0]       i_wchar,
    input  wire [15:0]      i_wdepth,
    output logic            o_ready,
    output logic [7:0]      o_rchar,
    output logic [15:0]     o_rdepth
);

    logic [7:0]       r_char_mem  [PIXELS];
    logic [15:0]      r_depth_mem [PIXELS];
    logic             r_clearing;
    logic [IDX_W-1:0] r_sweep;
    logic             m_we;
    logic [IDX_W-1:0] m_waddr;
    logic [7:0]       m_wchar;
    logic [15:0]      m_wdepth;

    assign o_ready = !r_clearing;

    // clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_sweep    <= '0;
        end else if (r_clearing) begin
            r_sweep <= r_sweep + 1'b1;
            if (r_sweep == IDX_W'(PIXELS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        m_we     = r_clearing || i_we;
        m_waddr  = r_clearing ? r_sweep : i_addr;
        m_wchar  = r_clearing ? BLANK_CHAR : i_wchar;
        m_wdepth = r_clearing ? MAX_DEPTH : i_wdepth;
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_char_mem[m_waddr]  <= m_wchar;
            r_depth_mem[m_waddr] <= m_wdepth;
        end
        if (i_rd) begin
            o_rchar  <= r_char_mem[i_addr];
            o_rdepth <= r_depth_mem[i_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/zbuffer_point_projector.sv
// Plot: rotation start, 4 rotation stages, serial divider, read-modify-write. Clear and no-op
// go straight to the result; a read first takes the registered store read. One word is in
// flight at a time, throughput set by the serial divider; a stalled result delays the next word.
// Reset (synchronous, active low) clears control and loads the identity
// rotation; the pixel store then sweeps all 4300 entries before words are taken.
// Depends on zbp_pkg, zbp_rotate, zbp_divider, zbp_store.
`default_nettype none
module zbuffer_point_projector
    import zbp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [2:0]   i_cfg_index,
    input  wire [15:0]  i_cfg_data,
    // input words
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [13:0] coord_i, [27:14] coord_j, [41:28] coord_k, [49:42] char_code,
    // [65:50] luminance, [78:66] pixel_index, [79] zero
    input  wire [79:0]  s_axis_tdata,
    // [1:0] command, [2] use_shade
    input  wire [2:0]   s_axis_tuser,
    // result words
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] result_char
    output logic [7:0]  m_axis_tdata,
    // [0] written, [1] rejected
    output logic [1:0]  m_axis_tuser
);

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_ROT  = 4'd3;
    localparam logic [3:0] ST_DIVS = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_CHK  = 4'd6;
    localparam logic [3:0] ST_RMW  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;
    localparam logic [3:0] ST_ROTS = 4'd9;

    logic [3:0] r_state, n_state;

    // configuration registers
    t_rot_cfg          r_cfg;
    logic signed [6:0] r_col_off;

    // latched word
    logic signed [13:0] r_ci, r_cj, r_ck;
    logic               r_use_shade;
    logic [7:0]         r_char_code;
    logic [15:0]        r_lum;

    // projection
    logic signed [Z_W-1:0]   r_z16;
    logic signed [NUM_W-1:0] r_num [2];
    logic [15:0]             r_depth;
    logic [IDX_W-1:0]        r_idx;

    // pending result
    logic [7:0] r_res_char, n_res_char;
    logic       r_res_wr, n_res_wr;
    logic       r_res_rej, n_res_rej;

    logic                  rot_valid;
    logic signed [Z_W-1:0] rot_x16, rot_y16, rot_z16;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quot [2];
    logic                  div_neg [2];
    logic                  st_ready;
    logic [7:0]            st_rchar;
    logic [15:0]           st_rdepth;

    logic                    acc;
    logic [1:0]              in_cmd;
    logic [12:0]             in_pix;
    logic                    in_pix_ok;
    logic                    rot_start, div_start;
    logic                    st_rd, st_we;
    logic [IDX_W-1:0]        st_addr;
    logic [7:0]              st_wchar;
    logic [15:0]             st_wdepth;
    logic                    col_ok, row_ok;
    logic [IDX_W-1:0]        m_idx;
    logic signed [NUM_W-1:0] m_base_col, m_base_row, m_z, m_x, m_y;
    logic [19:0]             m_lum11;
    logic [3:0]              m_shade_idx;
    logic [7:0]              m_char;
    logic                    out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tuser[1:0];
    assign in_pix        = s_axis_tdata[78:66];
    assign in_pix_ok     = (32'(in_pix) < PIXELS);
    assign out_free      = !m_axis_tvalid || m_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sin_a <= 16'sd0;
            r_cfg.cos_a <= 16'sd16384;
            r_cfg.sin_b <= 16'sd0;
            r_cfg.cos_b <= 16'sd16384;
            r_cfg.sin_c <= 16'sd0;
            r_cfg.cos_c <= 16'sd16384;
            r_col_off   <= 7'sd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SIN_A:   r_cfg.sin_a <= i_cfg_data;
                REG_COS_A:   r_cfg.cos_a <= i_cfg_data;
                REG_SIN_B:   r_cfg.sin_b <= i_cfg_data;
                REG_COS_B:   r_cfg.cos_b <= i_cfg_data;
                REG_SIN_C:   r_cfg.sin_c <= i_cfg_data;
                REG_COS_C:   r_cfg.cos_c <= i_cfg_data;
                REG_COL_OFF: r_col_off   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    zbp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_cfg   (r_cfg),
        .i_ci    (r_ci),
        .i_cj    (r_cj),
        .i_ck    (r_ck),
        .o_valid (rot_valid),
        .o_x16   (rot_x16),
        .o_y16   (rot_y16),
        .o_z16   (rot_z16)
    );

    zbp_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_z16),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_neg   (div_neg)
    );

    zbp_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (st_rd),
        .i_we     (st_we),
        .i_addr   (st_addr),
        .i_wchar  (st_wchar),
        .i_wdepth (st_wdepth),
        .o_ready  (st_ready),
        .o_rchar  (st_rchar),
        .o_rdepth (st_rdepth)
    );

    // projection numerators: base*z + gain*x, all exact in NUM_W bits
    always_comb begin
        m_base_col = NUM_W'(SCREEN_WIDTH / 2) + NUM_W'(r_col_off);
        m_base_row = NUM_W'(SCREEN_HEIGHT / 2);
        m_z        = NUM_W'(rot_z16);
        m_x        = NUM_W'(rot_x16);
        m_y        = NUM_W'(rot_y16);
    end

    // screen range check; truncation toward zero keeps small negatives at zero
    always_comb begin
        col_ok = (div_quot[0] == '0) ||
                 (!div_neg[0] && (div_quot[0] < NUM_W'(SCREEN_WIDTH)));
        row_ok = (div_quot[1] == '0) ||
                 (!div_neg[1] && (div_quot[1] < NUM_W'(SCREEN_HEIGHT)));
        m_idx  = IDX_W'(div_quot[1][ROW_W-1:0]) * IDX_W'(SCREEN_WIDTH)
               + IDX_W'(div_quot[0][COL_W-1:0]);
    end

    // character to plot
    always_comb begin
        m_lum11     = 20'(r_lum) * 20'd11;
        m_shade_idx = (m_lum11[19:15] > 5'd11) ? 4'd11 : m_lum11[18:15];
        m_char      = r_use_shade ? shade_char(m_shade_idx) : r_char_code;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_res_char = r_res_char;
        n_res_wr   = r_res_wr;
        n_res_rej  = r_res_rej;
        rot_start  = 1'b0;
        div_start  = 1'b0;
        st_rd      = 1'b0;
        st_we      = 1'b0;
        st_addr    = IDX_W'(in_pix);
        st_wchar   = BLANK_CHAR;
        st_wdepth  = MAX_DEPTH;
        unique case (r_state)
            ST_CLR: begin
                if (st_ready) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    n_res_char = 8'd0;
                    n_res_wr   = 1'b0;
                    n_res_rej  = 1'b0;
                    case (in_cmd)
                        CMD_PLOT: begin
                            n_state = ST_ROTS;
                        end
                        CMD_CLEAR: begin
                            st_we      = in_pix_ok;
                            n_res_char = BLANK_CHAR;
                            n_state    = ST_OUT;
                        end
                        CMD_READ: begin
                            st_rd   = in_pix_ok;
                            n_state = in_pix_ok ? ST_RD : ST_OUT;
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_RD: begin
                n_res_char = st_rchar;
                n_state    = ST_OUT;
            end
            // coordinates are latched now; start the rotation
            ST_ROTS: begin
                rot_start = 1'b1;
                n_state   = ST_ROT;
            end
            ST_ROT: begin
                if (rot_valid) begin
                    if (rot_z16 <= NEAR_Q16) begin
                        n_res_rej = 1'b1;
                        n_state   = ST_OUT;
                    end else begin
                        n_state = ST_DIVS;
                    end
                end
            end
            ST_DIVS: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) n_state = ST_CHK;
            end
            ST_CHK: begin
                if (col_ok && row_ok) begin
                    st_rd   = 1'b1;
                    st_addr = m_idx;
                    n_state = ST_RMW;
                end else begin
                    n_res_rej = 1'b1;
                    n_state   = ST_OUT;
                end
            end
            ST_RMW: begin
                st_addr   = r_idx;
                st_wchar  = m_char;
                st_wdepth = r_depth;
                if (r_depth < st_rdepth) begin
                    st_we      = 1'b1;
                    n_res_char = m_char;
                    n_res_wr   = 1'b1;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res_char <= n_res_char;
        r_res_wr   <= n_res_wr;
        r_res_rej  <= n_res_rej;
        if (acc) begin
            r_ci        <= s_axis_tdata[13:0];
            r_cj        <= s_axis_tdata[27:14];
            r_ck        <= s_axis_tdata[41:28];
            r_char_code <= s_axis_tdata[49:42];
            r_lum       <= s_axis_tdata[65:50];
            r_use_shade <= s_axis_tuser[2];
        end
        if (r_state == ST_ROT && rot_valid) begin
            r_z16    <= rot_z16;
            r_num[0] <= m_base_col * m_z + NUM_W'(2 * FOCAL) * m_x;
            r_num[1] <= m_base_row * m_z + NUM_W'(FOCAL) * m_y;
            r_depth  <= (rot_z16[Z_W-1:8] > (Z_W-8)'(SAT_DEPTH)) ? SAT_DEPTH
                                                                  : rot_z16[23:8];
        end
        if (r_state == ST_CHK) begin
            r_idx <= m_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            m_axis_tdata <= r_res_char;
            m_axis_tuser <= {r_res_rej, r_res_wr};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/zbp_checker.sv
// Port-level checks on the point projector, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module zbp_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       s_axis_tvalid,
    input wire       s_axis_tready,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata,
    input wire [1:0] m_axis_tuser
);

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // written and rejected exclude each other
    `ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

    // a rejected plot carries a null character
    `ASSERT_IMPL(a_rej_null, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == 8'd0)

    // one word at a time: input closes after an accept
    `ASSERT_NEXT(a_one_word, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind zbuffer_point_projector zbp_checker u_zbp_checker (.*);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for zbuffer_point_projector: directed table, then random words.
// Holds its own projector, depth store and character store to predict every result.
// Depends on zbp_pkg and the RTL of zbuffer_point_projector.
`default_nettype none
module testbench;
    import zbp_pkg::*;

    localparam int     WATCHDOG_LIMIT = 30000;
    localparam longint Q14_ONE        = 16384;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [13:0] ci;
        logic signed [13:0] cj;
        logic signed [13:0] ck;
        logic               shade;
        logic [7:0]         ch;
        logic [15:0]        lum;
        logic [12:0]        pix;
    } t_point_word;

    typedef struct {
        logic [7:0] ch;
        logic       written;
        logic       rejected;
    } t_pixel_result;

    typedef struct {
        t_point_word   w;
        bit            typed;
        t_pixel_result res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // predictor state
    logic signed [15:0] rot_sin_a, rot_cos_a, rot_sin_b, rot_cos_b, rot_sin_c, rot_cos_c;
    logic signed [6:0]  col_offset;
    logic [7:0]         char_mem  [PIXELS];
    logic [15:0]        depth_mem [PIXELS];

    t_pixel_result pending_results[$];
    int            error_count;
    int            idle_pct;
    int            stall_pct;
    int            quiet_cycles;

    zbuffer_point_projector i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Clear, read or no-op, or rotate, project and depth-test a plot, updating the stores
    function automatic t_pixel_result project_point(input t_point_word w);
        t_pixel_result r;
        longint ci, cj, ck, sa, ca, sb, cb, sc, cc;
        longint xr, yr, zr, x16, y16, z16, col, row, dep, sh;
        int idx;
        r = '{8'd0, 1'b0, 1'b0};
        case (w.cmd)
            CMD_CLEAR: begin
                if (w.pix < PIXELS) begin
                    char_mem[w.pix]  = BLANK_CHAR;
                    depth_mem[w.pix] = MAX_DEPTH;
                end
                r.ch = BLANK_CHAR;
                return r;
            end
            CMD_READ: begin
                if (w.pix < PIXELS) r.ch = char_mem[w.pix];
                return r;
            end
            CMD_NOP: return r;
            default: ;
        endcase
        ci = w.ci; cj = w.cj; ck = w.ck;
        sa = rot_sin_a; ca = rot_cos_a; sb = rot_sin_b;
        cb = rot_cos_b; sc = rot_sin_c; cc = rot_cos_c;
        xr = cj*sa*sb*cc - ck*ca*sb*cc + cj*ca*sc*Q14_ONE + ck*sa*sc*Q14_ONE
           + ci*cb*cc*Q14_ONE;
        yr = cj*ca*cc*Q14_ONE + ck*sa*cc*Q14_ONE - cj*sa*sb*sc + ck*ca*sb*sc
           - ci*cb*sc*Q14_ONE;
        zr = ck*ca*cb*Q14_ONE - cj*sa*cb*Q14_ONE + ci*sb*Q14_ONE*Q14_ONE;
        x16 = xr >>> 34;
        y16 = yr >>> 34;
        z16 = (zr >>> 34) + 64'sd120 * 65536;
        if (z16 <= 65) begin
            r.rejected = 1'b1;
            return r;
        end
        col = ((SCREEN_WIDTH / 2 + longint'(col_offset)) * z16 + 2 * FOCAL * x16) / z16;
        row = ((SCREEN_HEIGHT / 2) * z16 + FOCAL * y16) / z16;
        if (col < 0 || col >= SCREEN_WIDTH || row < 0 || row >= SCREEN_HEIGHT) begin
            r.rejected = 1'b1;
            return r;
        end
        idx = int'(row * SCREEN_WIDTH + col);
        dep = z16 >>> 8;
        if (dep > 64'sd65534) dep = 64'sd65534;
        if (dep >= longint'(depth_mem[idx])) return r;
        if (w.shade) begin
            sh = (longint'(w.lum) * 11) >>> 15;
            if (sh > 11) sh = 11;
            r.ch = shade_char(4'(sh));
        end else begin
            r.ch = w.ch;
        end
        depth_mem[idx] = dep[15:0];
        char_mem[idx]  = r.ch;
        r.written      = 1'b1;
        return r;
    endfunction

    // Drive one input word, honouring the sender idle rate
    task automatic send_word(input t_point_word w, input bit typed, input t_pixel_result want);
        t_pixel_result got;
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, w.pix, w.lum, w.ch, w.ck, w.cj, w.ci};
        s_axis_tuser  = {w.shade, w.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        got = project_point(w);
        pending_results.push_back(typed ? want : got);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SIN_A:   rot_sin_a  = val;
            REG_COS_A:   rot_cos_a  = val;
            REG_SIN_B:   rot_sin_b  = val;
            REG_COS_B:   rot_cos_b  = val;
            REG_SIN_C:   rot_sin_c  = val;
            REG_COS_C:   rot_cos_c  = val;
            REG_COL_OFF: col_offset = val[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic load_rotation(input logic [15:0] sa, ca, sb, cb, sc, cc,
                                 input logic [15:0] off);
        wait_drained();
        write_reg(REG_SIN_A, sa);
        write_reg(REG_COS_A, ca);
        write_reg(REG_SIN_B, sb);
        write_reg(REG_COS_B, cb);
        write_reg(REG_SIN_C, sc);
        write_reg(REG_COS_C, cc);
        write_reg(REG_COL_OFF, off);
    endtask

    function automatic t_point_word random_word();
        t_point_word w;
        int sel;
        sel     = $urandom_range(99);
        w.cmd   = sel < 60 ? CMD_PLOT : sel < 75 ? CMD_CLEAR : sel < 92 ? CMD_READ : CMD_NOP;
        w.ci    = 14'($urandom);
        w.cj    = 14'($urandom);
        w.ck    = 14'($urandom);
        // mostly small objects so points land on screen
        if ($urandom_range(3) != 0) begin
            w.ci = $signed(14'($urandom_range(6000))) - 14'sd3000;
            w.cj = $signed(14'($urandom_range(6000))) - 14'sd3000;
            w.ck = $signed(14'($urandom_range(6000))) - 14'sd3000;
        end
        w.shade = 1'($urandom);
        w.ch    = 8'($urandom);
        w.lum   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        w.pix   = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(PIXELS - 1));
        return w;
    endfunction

    // Receiver stall
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("unexpected result word: char %0d", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.ch) report("result_char", m_axis_tdata, want.ch);
                if (m_axis_tuser[0] !== want.written)
                    report("written", m_axis_tuser[0], want.written);
                if (m_axis_tuser[1] !== want.rejected)
                    report("rejected", m_axis_tuser[1], want.rejected);
            end
        end
    end

    // Watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row    rows[$];
        t_point_word  w;
        t_pixel_result none;
        int           n;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        error_count   = 0;
        quiet_cycles  = 0;
        none          = '{8'd0, 1'b0, 1'b0};
        rot_sin_a = 0; rot_cos_a = 16384; rot_sin_b = 0;
        rot_cos_b = 16384; rot_sin_c = 0; rot_cos_c = 16384;
        col_offset = 0;
        for (int p = 0; p < PIXELS; p++) begin
            char_mem[p]  = BLANK_CHAR;
            depth_mem[p] = MAX_DEPTH;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: typed rows for read-back after reset, clears, no-op
        rows = '{
            '{'{CMD_READ, 0, 0, 0, 0, 0, 0, 0},     1, '{8'd32, 1'b0, 1'b0}},
            '{'{CMD_READ, 0, 0, 0, 0, 0, 0, 4299},  1, '{8'd32, 1'b0, 1'b0}},
            '{'{CMD_READ, 0, 0, 0, 0, 0, 0, 4300},  1, '{8'd0, 1'b0, 1'b0}},
            '{'{CMD_READ, 0, 0, 0, 0, 0, 0, 8191},  1, '{8'd0, 1'b0, 1'b0}},
            '{'{CMD_NOP, -8192, 8191, -1, 1, 255, 65535, 8191}, 1, '{8'd0, 1'b0, 1'b0}},
            '{'{CMD_PLOT, 0, 0, 0, 0, 8'h41, 0, 0},  0, none},
            '{'{CMD_PLOT, 0, 0, 0, 0, 8'h42, 0, 0},  0, none},
            '{'{CMD_PLOT, 0, 0, -256, 1, 0, 0, 0},   0, none},
            '{'{CMD_PLOT, 0, 0, -512, 1, 0, 32768, 0}, 0, none},
            '{'{CMD_PLOT, 0, 0, -768, 1, 0, 65535, 0}, 0, none},
            '{'{CMD_PLOT, 0, 0, -1024, 1, 0, 2979, 0}, 0, none},
            '{'{CMD_PLOT, 8191, 8191, -8192, 0, 255, 0, 0}, 0, none},
            '{'{CMD_PLOT, -8192, -8192, -8192, 0, 1, 0, 0}, 0, none},
            '{'{CMD_PLOT, 8191, -8192, 8191, 0, 2, 0, 0}, 0, none},
            '{'{CMD_READ, 0, 0, 0, 0, 0, 0, 2150},  0, none},
            '{'{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 2150}, 1, '{8'd32, 1'b0, 1'b0}},
            '{'{CMD_READ, 0, 0, 0, 0, 0, 0, 2150},  1, '{8'd32, 1'b0, 1'b0}},
            '{'{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 8191}, 1, '{8'd32, 1'b0, 1'b0}},
            '{'{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 4300}, 1, '{8'd32, 1'b0, 1'b0}}
        };
        foreach (rows[r]) send_word(rows[r].w, rows[r].typed, rows[r].res);

        // Depth behind camera: both cosines at -2.0 give four times the depth
        load_rotation(16'd0, 16'h8000, 16'd0, 16'h8000, 16'd0, 16'd16384, 16'd0);
        w = '{CMD_PLOT, 0, 0, -8192, 0, 8'h58, 0, 0};
        send_word(w, 1, '{8'd0, 1'b0, 1'b1});
        w.ck = 8191;
        send_word(w, 0, none);

        // Random phases, each under a different rotation; the idle pattern repeats every four phases
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_rotation(0, 16384, 0, 16384, 0, 16384, 0);
                1: load_rotation(16384, 0, 16384, 0, 16384, 0, 16'h003F);
                2: load_rotation(16'hC000, 16'hC000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                 16'h8000, 16'h0040);
                3: load_rotation(11585, 11585, 16'($signed(-11585)), 11585, 8192, 14189,
                                 16'h7FE0);
                4: load_rotation(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
                default: load_rotation(6270, 15137, 16'($signed(-6270)), 15137, 0,
                                       16384, 16'h0010);
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            n = 175;
            for (int k = 0; k < n; k++) begin
                if (ph == 2 && k == 80) begin
                    // sender holds off until every result is back
                    while (pending_results.size() != 0) @(negedge i_clk);
                end
                send_word(random_word(), 0, none);
            end
        end

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/zbp_pkg.sv
rtl/core/zbp_rotate.sv
rtl/core/zbp_divider.sv
rtl/core/zbp_store.sv
rtl/core/zbuffer_point_projector.sv
rtl/core/zbp_checker.sv
sim/testbench.sv
